// File: design/bcce_pkg.sv
// ----------------------------------------------------------------------------
// bcce_pkg
// Shared types, register indexes and curve constants of the charge estimator.
// ----------------------------------------------------------------------------
package bcce_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIV_W = 18;
  localparam int unsigned SEG_N = 11;

  localparam logic [CFG_IDX_W-1:0] REG_CELLS_FROM_SENSOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_FROM_SENSOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESTIMATE_WINDOW_MS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EVAL_INTERVAL_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_CELL_MV = 3'd4;

  localparam logic [15:0] RST_ESTIMATE_WINDOW_MS = 16'd20000;
  localparam logic [15:0] RST_EVAL_INTERVAL_MS = 16'd500;
  localparam logic [15:0] RST_NOMINAL_CELL_MV = 16'd3900;

  localparam logic [4:0] CNT_MAX = 5'd31;
  localparam logic [15:0] CURVE_TOP_MV = 16'd4150;
  localparam logic [6:0] CHARGE_FULL = 7'd100;
  localparam logic [6:0] CHARGE_EMPTY = 7'd0;

  localparam logic [15:0] SEG_LO_MV [SEG_N] = '{
    16'd4100, 16'd3970, 16'd3920, 16'd3870, 16'd3830, 16'd3790,
    16'd3750, 16'd3700, 16'd3600, 16'd3300, 16'd3000
  };
  localparam logic [8:0] SEG_SPAN [SEG_N] = '{
    9'd50, 9'd130, 9'd50, 9'd50, 9'd40, 9'd40, 9'd40, 9'd50, 9'd100, 9'd300, 9'd300
  };
  localparam logic [6:0] SEG_LO_PC [SEG_N] = '{
    7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd5, 7'd0
  };
  localparam logic [3:0] SEG_RISE [SEG_N] = '{
    4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd5, 4'd5
  };

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_CHECK   = 9'b000000010,
    S_EST     = 9'b000000100,
    S_CELL    = 9'b000001000,
    S_CELLDIV = 9'b000010000,
    S_SEL     = 9'b000100000,
    S_SEG     = 9'b001000000,
    S_CURVE   = 9'b010000000,
    S_OUT     = 9'b100000000
  } state_e;

  typedef enum logic [1:0] {
    DIV_EST   = 2'd0,
    DIV_CELL  = 2'd1,
    DIV_CURVE = 2'd2
  } div_op_e;

  typedef struct packed {
    logic    load_in;
    logic    set_due;
    logic    open_win;
    logic    div_start;
    div_op_e div_op;
    logic    held_from_div;
    logic    held_full;
    logic    cell_from_div;
    logic    seg_capture;
    logic    charge_direct;
    logic    charge_from_div;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic due;
    logic cells_en;
    logic charge_en;
    logic in_window;
    logic nom_zero;
    logic held_zero;
    logic div_done;
    logic seg_direct;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic        direct;
    logic [6:0]  base_pc;
    logic [15:0] lo_mv;
    logic [3:0]  rise;
    logic [8:0]  span;
  } seg_t;

  function automatic seg_t seg_lookup(logic [15:0] mv);
    seg_t s;
    logic found;
    s = '{direct: 1'b1, base_pc: CHARGE_EMPTY, lo_mv: 16'd0, rise: 4'd0, span: 9'd1};
    found = 1'b0;
    if (mv > CURVE_TOP_MV) begin
      s.base_pc = CHARGE_FULL;
      found = 1'b1;
    end
    for (int k = 0; k < SEG_N; k++) begin
      if (!found && mv > SEG_LO_MV[k]) begin
        found = 1'b1;
        s.direct = 1'b0;
        s.base_pc = SEG_LO_PC[k];
        s.lo_mv = SEG_LO_MV[k];
        s.rise = SEG_RISE[k];
        s.span = SEG_SPAN[k];
      end
    end
    return s;
  endfunction

endpackage

// File: design/bcce_div.sv
// ----------------------------------------------------------------------------
// bcce_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcce_div #(
  parameter int unsigned W = 18
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W:0]    rem_q, rem_d, rem_sh;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic          ge;

  assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      cnt_d = CW'(W);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_d  = {quo_q[W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: design/bcce_ctrl.sv
// ----------------------------------------------------------------------------
// bcce_ctrl
// Sequencer: due check, cell estimate, per-cell voltage, charge curve, output.
// ----------------------------------------------------------------------------
module bcce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bcce_pkg::status_t sts_i,
  output bcce_pkg::cmd_t    cmd_o
);

  bcce_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_op = bcce_pkg::DIV_EST;
    case (state_q)
      bcce_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = bcce_pkg::S_CHECK;
        end
      end
      bcce_pkg::S_CHECK: begin
        if (!sts_i.due) begin
          state_d = bcce_pkg::S_IDLE;
        end else begin
          cmd_o.set_due = 1'b1;
          if (sts_i.cells_en) begin
            cmd_o.open_win = 1'b1;
            if (!sts_i.in_window) begin
              state_d = bcce_pkg::S_CELL;
            end else if (sts_i.nom_zero) begin
              cmd_o.held_full = 1'b1;
              state_d = bcce_pkg::S_CELL;
            end else begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_op = bcce_pkg::DIV_EST;
              state_d = bcce_pkg::S_EST;
            end
          end else begin
            state_d = bcce_pkg::S_SEL;
          end
        end
      end
      bcce_pkg::S_EST: begin
        if (sts_i.div_done) begin
          cmd_o.held_from_div = 1'b1;
          state_d = bcce_pkg::S_CELL;
        end
      end
      bcce_pkg::S_CELL: begin
        if (sts_i.held_zero) begin
          state_d = bcce_pkg::S_SEL;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op = bcce_pkg::DIV_CELL;
          state_d = bcce_pkg::S_CELLDIV;
        end
      end
      bcce_pkg::S_CELLDIV: begin
        if (sts_i.div_done) begin
          cmd_o.cell_from_div = 1'b1;
          state_d = bcce_pkg::S_SEL;
        end
      end
      bcce_pkg::S_SEL: begin
        if (sts_i.charge_en) begin
          cmd_o.seg_capture = 1'b1;
          state_d = bcce_pkg::S_SEG;
        end else begin
          state_d = bcce_pkg::S_OUT;
        end
      end
      bcce_pkg::S_SEG: begin
        if (sts_i.seg_direct) begin
          cmd_o.charge_direct = 1'b1;
          state_d = bcce_pkg::S_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op = bcce_pkg::DIV_CURVE;
          state_d = bcce_pkg::S_CURVE;
        end
      end
      bcce_pkg::S_CURVE: begin
        if (sts_i.div_done) begin
          cmd_o.charge_from_div = 1'b1;
          state_d = bcce_pkg::S_OUT;
        end
      end
      bcce_pkg::S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = bcce_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bcce_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcce_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == bcce_pkg::S_IDLE);

endmodule

// File: design/bcce_dp.sv
// ----------------------------------------------------------------------------
// bcce_dp
// Datapath: config registers, timing state, shared divider, output register.
// ----------------------------------------------------------------------------
module bcce_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bcce_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bcce_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [63:0]                        in_data_i,
  input  bcce_pkg::cmd_t                     cmd_i,
  output bcce_pkg::status_t                  sts_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [31:0]                        out_data_o,
  output logic [1:0]                         out_user_o
);

  localparam int unsigned DW = bcce_pkg::DIV_W;

  logic        cells_sens_q, charge_sens_q;
  logic [15:0] window_q, interval_q, nominal_q;

  logic [31:0] now_q;
  logic [15:0] pack_q, sens_q;
  logic [31:0] next_due_q;
  logic [31:0] win_end_q;
  logic        win_started_q;
  logic [4:0]  held_q;
  logic [15:0] cell_q;
  logic [6:0]  charge_q;
  bcce_pkg::seg_t seg_q;

  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic [1:0]  out_user_q;

  logic [31:0]   win_open_sum, win_end_eff;
  logic [15:0]   lowest, seg_diff;
  logic [12:0]   curve_num;
  logic [DW-1:0] div_num, div_den, div_quo;
  logic          div_done;
  logic [4:0]    count_out;
  logic [15:0]   cell_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_sens_q  <= 1'b0;
      charge_sens_q <= 1'b0;
      window_q      <= bcce_pkg::RST_ESTIMATE_WINDOW_MS;
      interval_q    <= bcce_pkg::RST_EVAL_INTERVAL_MS;
      nominal_q     <= bcce_pkg::RST_NOMINAL_CELL_MV;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bcce_pkg::REG_CELLS_FROM_SENSOR:  cells_sens_q  <= cfg_data_i[0];
        bcce_pkg::REG_CHARGE_FROM_SENSOR: charge_sens_q <= cfg_data_i[0];
        bcce_pkg::REG_ESTIMATE_WINDOW_MS: window_q      <= cfg_data_i;
        bcce_pkg::REG_EVAL_INTERVAL_MS:   interval_q    <= cfg_data_i;
        bcce_pkg::REG_NOMINAL_CELL_MV:    nominal_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign win_open_sum = now_q + {16'd0, window_q};
  assign win_end_eff  = win_started_q ? win_end_q : win_open_sum;
  assign lowest       = cells_sens_q ? sens_q : cell_q;
  assign seg_diff     = lowest - seg_q.lo_mv;
  assign curve_num    = 13'(seg_diff[8:0]) * 13'(seg_q.rise);

  always_comb begin
    case (cmd_i.div_op)
      bcce_pkg::DIV_EST: begin
        div_num = DW'({pack_q, 1'b0}) + DW'(nominal_q);
        div_den = DW'({nominal_q, 1'b0});
      end
      bcce_pkg::DIV_CELL: begin
        div_num = DW'(pack_q);
        div_den = DW'(held_q);
      end
      bcce_pkg::DIV_CURVE: begin
        div_num = DW'(curve_num);
        div_den = DW'(seg_q.span);
      end
      default: begin
        div_num = '0;
        div_den = '1;
      end
    endcase
  end

  bcce_div #(
    .W(DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_due_q    <= '0;
      win_end_q     <= '0;
      win_started_q <= 1'b0;
      held_q        <= '0;
    end else begin
      if (cmd_i.set_due) begin
        next_due_q <= now_q + {16'd0, interval_q};
      end
      if (cmd_i.open_win && !win_started_q) begin
        win_started_q <= 1'b1;
        win_end_q     <= win_open_sum;
      end
      if (cmd_i.held_full) begin
        held_q <= bcce_pkg::CNT_MAX;
      end else if (cmd_i.held_from_div) begin
        held_q <= (div_quo > DW'(bcce_pkg::CNT_MAX)) ? bcce_pkg::CNT_MAX : div_quo[4:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      now_q    <= in_data_i[31:0];
      pack_q   <= in_data_i[47:32];
      sens_q   <= in_data_i[63:48];
      cell_q   <= '0;
      charge_q <= '0;
    end
    if (cmd_i.cell_from_div) begin
      cell_q <= div_quo[15:0];
    end
    if (cmd_i.seg_capture) begin
      seg_q <= bcce_pkg::seg_lookup(lowest);
    end
    if (cmd_i.charge_direct) begin
      charge_q <= seg_q.base_pc;
    end else if (cmd_i.charge_from_div) begin
      charge_q <= seg_q.base_pc + div_quo[6:0];
    end
  end

  assign count_out = cells_sens_q ? 5'd0 : held_q;
  assign cell_out  = cells_sens_q ? 16'd0 : cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {4'd0, charge_q, cell_out, count_out};
      out_user_q <= {!charge_sens_q, !cells_sens_q};
    end
  end

  assign sts_o.due        = next_due_q <= now_q;
  assign sts_o.cells_en   = !cells_sens_q;
  assign sts_o.charge_en  = !charge_sens_q;
  assign sts_o.in_window  = win_end_eff > now_q;
  assign sts_o.nom_zero   = (nominal_q == 16'd0);
  assign sts_o.held_zero  = (held_q == 5'd0);
  assign sts_o.div_done   = div_done;
  assign sts_o.seg_direct = seg_q.direct;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

// File: design/battery_cell_charge_estimator_top.sv
// ----------------------------------------------------------------------------
// battery_cell_charge_estimator_top
// Cell count, per-cell voltage and state of charge from pack telemetry.
// ----------------------------------------------------------------------------
// One word is taken at a time. A word whose timestamp is before the next due
// time is dropped with no result. A shared 18-step serial divider runs up to
// three times per evaluation (count estimate, pack over count, curve
// segment) and not at all when both estimates come from sensors; sequencing
// states and a final load into the output register complete it. The output
// register lets a new word enter while a result waits.
module battery_cell_charge_estimator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bcce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bcce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,  // now_ms, pack_mv, sensor_lowest_mv
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,  // cell_count, cell_mv, charge_percent
  output logic [1:0]                      m_axis_tuser   // cells_valid, charge_valid
);

  bcce_pkg::cmd_t    cmd;
  bcce_pkg::status_t sts;

  bcce_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bcce_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser)
  );

endmodule

// File: design/bcce_chk.sv
// ----------------------------------------------------------------------------
// bcce_chk
// Port-level checks of the charge estimator, bound to the top level.
// ----------------------------------------------------------------------------
module bcce_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_cells_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[20:0] == 21'd0)
    else $error("cell fields nonzero without cells_valid");

  a_charge_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[27:21] == 7'd0)
    else $error("charge nonzero without charge_valid");

  a_charge_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[27:21] <= bcce_pkg::CHARGE_FULL)
    else $error("charge above full");

  a_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4:0] == 5'd0 |-> m_axis_tdata[20:5] == 16'd0)
    else $error("cell voltage nonzero with zero count");

endmodule

bind battery_cell_charge_estimator_top bcce_chk u_bcce_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
